// ===== sv/swd_pkg.sv =====
// Shared constants, types and the quarter-wave gain table for the stereo width block.
// The table is built at elaboration from a fixed-point sine series; no other dependencies.
package swd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_TABLE_DEPTH = 64;
  localparam int GAIN_BITS = 18;
  localparam int WIDTH_BITS = 13;
  localparam int FRAC_BITS = 13;
  localparam int ROM_IDX_W = $clog2(GAIN_TABLE_DEPTH + 1);
  localparam int POS_W = FRAC_BITS + 1 + ROM_IDX_W;

  localparam logic [WIDTH_BITS-1:0] WIDTH_FULL = 13'd4096;
  localparam logic [WIDTH_BITS:0] WIDTH_SPAN = 14'd8192;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 18'd131072;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] INV_SQRT2_Q30 = 64'd759250125;

  typedef logic [GAIN_BITS-1:0] rom_t [0:GAIN_TABLE_DEPTH];

  // Point k holds sin(pi/2 * k / depth) / sqrt(2) in Q0.18.
  function automatic rom_t build_rom();
    rom_t rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] p;
    logic signed [63:0] acc;
    for (int k = 0; k <= GAIN_TABLE_DEPTH; k++) begin
      x = (HALF_PI_Q30 * 64'(k)) / 64'(GAIN_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      term = x;
      acc = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;
      acc = acc - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;
      acc = acc + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;
      acc = acc - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;
      acc = acc + signed'(term);
      term = ((term * x2) >> 30) / 64'd110;
      acc = acc - signed'(term);
      term = ((term * x2) >> 30) / 64'd156;
      acc = acc + signed'(term);
      if (acc < 0) begin
        acc = 64'sd0;
      end
      p = unsigned'(acc) * INV_SQRT2_Q30;
      rom[k] = GAIN_BITS'((p + (64'd1 << 41)) >> 42);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

endpackage

// ===== sv/stereo_width_downmix.sv =====
// Mid/side stereo width control: one stereo pair in, one re-mixed pair out per beat.
// One beat per cycle is sustained while out_ready stays high; out_ready low stalls the
// four-stage add, multiply, combine and round/saturate pipeline.
// Gains are interpolated from the package sine table at the configuration write edge.
// Synchronous reset empties the pipeline, sets width to 4096 and both gains to 0.5.
// Depends on swd_pkg.
module stereo_width_downmix
  import swd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  input  logic                          block_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  output logic                          block_end_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int SUM_W = SAMPLE_BITS + 1;
  localparam int PROD_W = SUM_W + GAIN_BITS + 1;
  localparam int ACC_W = PROD_W + 1;
  localparam int SH_W = ACC_W - GAIN_BITS;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (GAIN_BITS - 1);
  localparam logic signed [SH_W-1:0] SAT_HI =
    {{(SH_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SH_W-1:0] SAT_LO =
    {{(SH_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  logic [WIDTH_BITS-1:0] stereo_width;
  logic [GAIN_BITS-1:0]  mid_gain;
  logic [GAIN_BITS-1:0]  side_gain;
  logic                  cfg_write;
  logic [WIDTH_BITS-1:0] width_clamp;
  logic [POS_W-1:0]      pos_side;
  logic [POS_W-1:0]      pos_mid;
  logic [GAIN_BITS-1:0]  side_gain_next;
  logic [GAIN_BITS-1:0]  mid_gain_next;

  function automatic logic [GAIN_BITS-1:0] gain_lookup(input logic [POS_W-1:0] pos);
    logic [POS_W-FRAC_BITS-1:0] idx;
    logic [FRAC_BITS-1:0]       frac;
    logic [ROM_IDX_W-1:0]       ia;
    logic [ROM_IDX_W-1:0]       ib;
    logic [GAIN_BITS-1:0]       a;
    logic [GAIN_BITS-1:0]       b;
    logic [31:0]                prod;
    logic [GAIN_BITS-1:0]       res;
    idx = pos[POS_W-1:FRAC_BITS];
    frac = pos[FRAC_BITS-1:0];
    if (idx > (POS_W - FRAC_BITS)'(GAIN_TABLE_DEPTH)) begin
      idx = (POS_W - FRAC_BITS)'(GAIN_TABLE_DEPTH);
    end
    ia = idx[ROM_IDX_W-1:0];
    ib = (idx >= (POS_W - FRAC_BITS)'(GAIN_TABLE_DEPTH)) ? ia : ia + ROM_IDX_W'(1);
    a = SINE_ROM[ia];
    b = SINE_ROM[ib];
    prod = 32'd0;
    if (frac == '0 || idx >= (POS_W - FRAC_BITS)'(GAIN_TABLE_DEPTH)) begin
      res = a;
    end else if (b >= a) begin
      prod = 32'(b - a) * 32'(frac) + 32'd4096;
      res = a + prod[FRAC_BITS+GAIN_BITS-1:FRAC_BITS];
    end else begin
      prod = 32'(a - b) * 32'(frac) + 32'd4095;
      res = a - prod[FRAC_BITS+GAIN_BITS-1:FRAC_BITS];
    end
    return res;
  endfunction

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(stereo_width);

  always_comb begin
    width_clamp = (pwdata[WIDTH_BITS-1:0] > WIDTH_FULL) ? WIDTH_FULL : pwdata[WIDTH_BITS-1:0];
    pos_side = POS_W'(width_clamp) * POS_W'(GAIN_TABLE_DEPTH);
    pos_mid = POS_W'(WIDTH_SPAN - (WIDTH_BITS + 1)'(width_clamp)) * POS_W'(GAIN_TABLE_DEPTH);
    side_gain_next = gain_lookup(pos_side);
    mid_gain_next = gain_lookup(pos_mid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_width <= WIDTH_FULL;
      mid_gain <= GAIN_RESET;
      side_gain <= GAIN_RESET;
    end else if (cfg_write) begin
      stereo_width <= pwdata[WIDTH_BITS-1:0];
      mid_gain <= mid_gain_next;
      side_gain <= side_gain_next;
    end
  end

  logic                    v1, v2, v3, v4;
  logic                    rdy1, rdy2, rdy3, rdy4;
  logic signed [SUM_W-1:0]  sum1, dif1;
  logic                    be1, be2, be3, be4;
  logic signed [PROD_W-1:0] mid2, side2;
  logic signed [ACC_W-1:0]  acc_l3, acc_r3;
  logic signed [SH_W-1:0]   sh_l, sh_r;
  logic signed [SAMPLE_BITS-1:0] sat_l, sat_r;
  logic signed [SAMPLE_BITS-1:0] out_l4, out_r4;

  assign rdy4 = !v4 || out_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    sh_l = SH_W'(acc_l3 >>> GAIN_BITS);
    sh_r = SH_W'(acc_r3 >>> GAIN_BITS);
    if (sh_l > SAT_HI) begin
      sat_l = SAT_HI[SAMPLE_BITS-1:0];
    end else if (sh_l < SAT_LO) begin
      sat_l = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_l = sh_l[SAMPLE_BITS-1:0];
    end
    if (sh_r > SAT_HI) begin
      sat_r = SAT_HI[SAMPLE_BITS-1:0];
    end else if (sh_r < SAT_LO) begin
      sat_r = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_r = sh_r[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      sum1 <= SUM_W'(left_in) + SUM_W'(right_in);
      dif1 <= SUM_W'(left_in) - SUM_W'(right_in);
      be1 <= block_end;
    end
    if (rdy2 && v1) begin
      mid2 <= PROD_W'(sum1) * PROD_W'($signed({1'b0, mid_gain}));
      side2 <= PROD_W'(dif1) * PROD_W'($signed({1'b0, side_gain}));
      be2 <= be1;
    end
    if (rdy3 && v2) begin
      acc_l3 <= ACC_W'(mid2) + ACC_W'(side2) + ROUND_HALF;
      acc_r3 <= ACC_W'(mid2) - ACC_W'(side2) + ROUND_HALF;
      be3 <= be2;
    end
    if (rdy4 && v3) begin
      out_l4 <= sat_l;
      out_r4 <= sat_r;
      be4 <= be3;
    end
  end

  assign out_valid = v4;
  assign left_out = out_l4;
  assign right_out = out_r4;
  assign block_end_out = be4;

endmodule

// ===== sv/swd_checker.sv =====
// Port-level checks for the stereo width block, attached to stereo_width_downmix by bind.
// Depends on swd_pkg and the stereo_width_downmix port list.
module swd_checker
  import swd_pkg::*;
(
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] left_out,
  input logic signed [SAMPLE_BITS-1:0] right_out,
  input logic                          block_end_out,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [2:0]                    paddr,
  input logic [31:0]                   pwdata,
  input logic [31:0]                   prdata
);

  // An empty output stage must never hold off the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low while no output beat is pending");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat present right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out)
      && $stable(block_end_out))
    else $error("stalled output beat changed");

  a_width_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && !paddr[2] |=>
      (paddr[2] || prdata == {19'd0, $past(pwdata[12:0])}))
    else $error("width register readback differs from last write");

endmodule

bind stereo_width_downmix swd_checker u_swd_checker (.*);

// ===== tb/sv/stereo_width_downmix_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for stereo_width_downmix: streams stereo pairs with random idling on
// both handshakes, sets the width register over APB, and checks every mixed pair against its
// own mid/side gain predictor. Depends on swd_pkg and the stereo_width_downmix RTL.
module stereo_width_downmix_test;
  import swd_pkg::*;

  localparam logic [2:0] WIDTH_REG_ADDR = 3'd0;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PIPE_DRAIN_CYCLES = 12;
  localparam longint unsigned TABLE_DEPTH_U = GAIN_TABLE_DEPTH;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          last;
  } stereo_pair_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          block_end;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          block_end_out;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [2:0]                    paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  logic [GAIN_BITS-1:0]  sine_points [0:GAIN_TABLE_DEPTH];
  logic [WIDTH_BITS-1:0] width_reg;
  logic [GAIN_BITS-1:0]  mid_gain_q;
  logic [GAIN_BITS-1:0]  side_gain_q;
  stereo_pair_t          mixed_q [$];

  int idle_pct = 37;
  int buffer_left = 0;
  int error_count = 0;
  int pairs_sent = 0;
  int pairs_checked = 0;
  int width_writes = 0;
  int saturated_count = 0;

  stereo_width_downmix u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .left_in(left_in), .right_in(right_in), .block_end(block_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_out(left_out), .right_out(right_out), .block_end_out(block_end_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  function automatic logic [GAIN_BITS-1:0] sine_point(longint unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned p;
    longint          acc;
    x = (HALF_PI_Q30 * k) / TABLE_DEPTH_U;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (longint unsigned n = 1; n <= 6; n++) begin
      term = (term * x2) >> 30;
      term = term / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    p = longint'(acc) * INV_SQRT2_Q30;
    return GAIN_BITS'((p + (64'd1 << 41)) >> 42);
  endfunction

  function automatic void build_sine_points();
    for (int k = 0; k <= GAIN_TABLE_DEPTH; k++) begin
      sine_points[k] = sine_point(longint'(k));
    end
  endfunction

  function automatic logic [GAIN_BITS-1:0] gain_at(longint unsigned pos);
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned a;
    longint unsigned b;
    idx = pos >> FRAC_BITS;
    frac = pos & 64'd8191;
    if (idx > TABLE_DEPTH_U) begin
      idx = TABLE_DEPTH_U;
    end
    a = sine_points[idx];
    if (frac == 0 || idx >= TABLE_DEPTH_U) begin
      return GAIN_BITS'(a);
    end
    b = sine_points[idx + 1];
    if (b >= a) begin
      return GAIN_BITS'(a + (((b - a) * frac + 64'd4096) >> 13));
    end
    return GAIN_BITS'(a - (((a - b) * frac + 64'd4095) >> 13));
  endfunction

  function automatic void set_width(logic [WIDTH_BITS-1:0] value);
    longint unsigned w;
    width_reg = value;
    w = (value > WIDTH_FULL) ? longint'(WIDTH_FULL) : longint'(value);
    side_gain_q = gain_at(w * TABLE_DEPTH_U);
    mid_gain_q = gain_at((64'd8192 - w) * TABLE_DEPTH_U);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(longint v);
    longint r;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    r = (v + (longint'(1) <<< 17)) >>> 18;
    if (r > hi) begin
      r = hi;
    end
    if (r < lo) begin
      r = lo;
    end
    return SAMPLE_BITS'(r);
  endfunction

  function automatic stereo_pair_t mix_pair(logic signed [SAMPLE_BITS-1:0] l,
                                            logic signed [SAMPLE_BITS-1:0] r, logic last);
    longint lv;
    longint rv;
    longint mg;
    longint sg;
    longint mid;
    longint side;
    stereo_pair_t res;
    lv = l;
    rv = r;
    mg = mid_gain_q;
    sg = side_gain_q;
    mid = (lv + rv) * mg;
    side = (lv - rv) * sg;
    res.left = round_sat(mid + side);
    res.right = round_sat(mid - side);
    res.last = last;
    return res;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic next_block_end();
    if (buffer_left == 0) begin
      buffer_left = $urandom_range(1, 32);
    end
    buffer_left--;
    return buffer_left == 0;
  endfunction

  task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] l,
                           input logic signed [SAMPLE_BITS-1:0] r, input logic last);
    stereo_pair_t want;
    left_in = l;
    right_in = r;
    block_end = last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    want = mix_pair(l, r, last);
    mixed_q.push_back(want);
    pairs_sent++;
    if (want.left == SAMPLE_MAX || want.left == SAMPLE_MIN ||
        want.right == SAMPLE_MAX || want.right == SAMPLE_MIN) begin
      saturated_count++;
    end
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
  endtask

  task automatic send_random_pair();
    logic signed [SAMPLE_BITS-1:0] l;
    logic signed [SAMPLE_BITS-1:0] r;
    l = random_sample();
    case ($urandom_range(0, 19))
      0: r = l;
      1: r = -l;
      default: r = random_sample();
    endcase
    send_pair(l, r, next_block_end());
  endtask

  task automatic quiesce();
    in_valid = 1'b0;
    while (mixed_q.size() != 0) @(negedge clk);
    repeat (PIPE_DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = WIDTH_REG_ADDR;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    set_width(data[WIDTH_BITS-1:0]);
    width_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apb_read_check();
    logic [31:0] got;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = WIDTH_REG_ADDR;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== 32'(width_reg)) begin
      error_count++;
      $display("%0t: stereo_width readback mismatch: expected %0d, actual %0d",
               $time, width_reg, got);
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic send_extreme_pairs();
    send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_pair('1, SAMPLE_BITS'(1), 1'b1);
  endtask

  task automatic test_reset_state();
    apb_read_check();
    send_extreme_pairs();
    quiesce();
  endtask

  task automatic test_width_extremes();
    logic [31:0] settings [3];
    settings[0] = 32'd0;
    settings[1] = 32'd8191;
    settings[2] = 32'hFFFF_E001;
    for (int i = 0; i < 3; i++) begin
      apb_write(settings[i]);
      apb_read_check();
      send_extreme_pairs();
      quiesce();
    end
  endtask

  task automatic test_random_widths();
    logic [31:0] value;
    int count;
    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 7))
        0: value = 32'd0;
        1: value = 32'(WIDTH_FULL);
        2: value = $urandom_range(4097, 8191);
        default: value = $urandom_range(0, 4096);
      endcase
      apb_write(value);
      apb_read_check();
      count = $urandom_range(60, 190);
      repeat (count) send_random_pair();
      quiesce();
    end
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    apb_write($urandom_range(0, 4096));
    repeat (330) send_random_pair();
    quiesce();
    idle_pct = 37;
  endtask

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= idle_pct);
  end

  always @(posedge clk) begin
    stereo_pair_t want;
    if (!rst && out_valid && out_ready) begin
      if (mixed_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected mixed pair: expected none, actual left %0d right %0d",
                 $time, left_out, right_out);
      end else begin
        want = mixed_q.pop_front();
        pairs_checked++;
        if (left_out !== want.left) begin
          error_count++;
          $display("%0t: left_out mismatch: expected %0d, actual %0d",
                   $time, want.left, left_out);
        end
        if (right_out !== want.right) begin
          error_count++;
          $display("%0t: right_out mismatch: expected %0d, actual %0d",
                   $time, want.right, right_out);
        end
        if (block_end_out !== want.last) begin
          error_count++;
          $display("%0t: block_end_out mismatch: expected %0b, actual %0b",
                   $time, want.last, block_end_out);
        end
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    left_in = '0;
    right_in = '0;
    block_end = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    build_sine_points();
    width_reg = WIDTH_FULL;
    mid_gain_q = GAIN_RESET;
    side_gain_q = GAIN_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_width_extremes();
    test_random_widths();
    test_back_to_back();

    repeat (PIPE_DRAIN_CYCLES) @(posedge clk);
    if (mixed_q.size() != 0) begin
      error_count += mixed_q.size();
      $display("%0t: %0d mixed pairs never arrived", $time, mixed_q.size());
    end
    $display("Streamed %0d stereo pairs through %0d width writes, %0d mixed pairs compared.",
             pairs_sent, width_writes, pairs_checked);
    $display("Widths ranged over mono, full stereo and above-range values; %0d results at a rail.",
             saturated_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== stereo_width_downmix.f =====
sv/swd_pkg.sv
sv/stereo_width_downmix.sv
sv/swd_checker.sv
tb/sv/stereo_width_downmix_test.sv
